[rtl/adem_pkg.sv]
// Shared types, constants and register codes for the dead-band EMA g-force plotter.
package adem_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Shared serial divider: dividend = divisor width + quotient width
   localparam int DIV_DVS_W = 21;
   localparam int DIV_QUO_W = 16;
   localparam int DIV_DVD_W = DIV_DVS_W + DIV_QUO_W;

   // m/s^2 Q8.8 to g Q3.12: round(mag * 1600000 / 980665), done as
   // (2*mag*1600000 + 980665) / 1961330
   localparam logic signed [22:0]          G_SCALE   = 23'sd3200000;
   localparam logic [DIV_DVD_W-1:0]        G_ROUND   = 37'd980665;
   localparam logic [DIV_DVS_W-1:0]        G_DIVISOR = 21'd1961330;

   // Jerk thresholds: jerk*20 > 4096 and jerk*50 > 4096
   localparam logic [17:0] JERK_HIGH = 18'd205;
   localparam logic [17:0] JERK_MID  = 18'd82;

   localparam logic [12:0] ALPHA_ONE = 13'd4096;

   typedef enum logic [2:0] {
      REG_DB_BASE   = 3'd0,
      REG_DB_MIN    = 3'd1,
      REG_ALPHA     = 3'd2,
      REG_KNEE      = 3'd3,
      REG_INNER     = 3'd4,
      REG_OUTER     = 3'd5,
      REG_CENTER    = 3'd6,
      REG_THRESHOLD = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [11:0] dead_band_base;
      logic [11:0] dead_band_min;
      logic [12:0] smoothing_alpha;
      logic [11:0] knee_level;
      logic [7:0]  inner_radius;
      logic [7:0]  outer_radius;
      logic [8:0]  plot_center;
      logic [7:0]  move_threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dead_band_base:  12'd328,
      dead_band_min:   12'd82,
      smoothing_alpha: 13'd1229,
      knee_level:      12'd1229,
      inner_radius:    8'd80,
      outer_radius:    8'd160,
      plot_center:     9'd233,
      move_threshold:  8'd32
   };

   typedef struct packed {
      logic               mode;
      logic signed [15:0] accel_lateral;
      logic signed [15:0] accel_vertical;
   } req_item_type;

   typedef struct packed {
      logic [8:0]         marker_x;
      logic [8:0]         marker_y;
      logic               moved;
      logic signed [15:0] filtered_x;
      logic signed [15:0] filtered_y;
   } rsp_item_type;

endpackage

[rtl/adem_csr.sv]
// Configuration register file with APB-style access.
module adem_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [adem_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [adem_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [adem_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output adem_pkg::cfg_type                  cfg
);

   adem_pkg::cfg_type       cfg_ff, cfg_in;
   adem_pkg::reg_index_type index;
   logic                    wr_en;

   assign index  = adem_pkg::reg_index_type'(paddr[adem_pkg::CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            adem_pkg::REG_DB_BASE:   cfg_in.dead_band_base  = pwdata[11:0];
            adem_pkg::REG_DB_MIN:    cfg_in.dead_band_min   = pwdata[11:0];
            adem_pkg::REG_ALPHA:     cfg_in.smoothing_alpha = pwdata[12:0];
            adem_pkg::REG_KNEE:      cfg_in.knee_level      = pwdata[11:0];
            adem_pkg::REG_INNER:     cfg_in.inner_radius    = pwdata[7:0];
            adem_pkg::REG_OUTER:     cfg_in.outer_radius    = pwdata[7:0];
            adem_pkg::REG_CENTER:    cfg_in.plot_center     = pwdata[8:0];
            adem_pkg::REG_THRESHOLD: cfg_in.move_threshold  = pwdata[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         adem_pkg::REG_DB_BASE:   prdata = 32'(cfg_ff.dead_band_base);
         adem_pkg::REG_DB_MIN:    prdata = 32'(cfg_ff.dead_band_min);
         adem_pkg::REG_ALPHA:     prdata = 32'(cfg_ff.smoothing_alpha);
         adem_pkg::REG_KNEE:      prdata = 32'(cfg_ff.knee_level);
         adem_pkg::REG_INNER:     prdata = 32'(cfg_ff.inner_radius);
         adem_pkg::REG_OUTER:     prdata = 32'(cfg_ff.outer_radius);
         adem_pkg::REG_CENTER:    prdata = 32'(cfg_ff.plot_center);
         adem_pkg::REG_THRESHOLD: prdata = 32'(cfg_ff.move_threshold);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= adem_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/adem_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module adem_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [adem_pkg::DIV_DVD_W-1:0]    dividend,
   input  logic [adem_pkg::DIV_DVS_W-1:0]    divisor,
   output logic                              done,
   output logic [adem_pkg::DIV_QUO_W-1:0]    quotient
);

   localparam int DVS_W = adem_pkg::DIV_DVS_W;
   localparam int QUO_W = adem_pkg::DIV_QUO_W;
   localparam int DVD_W = adem_pkg::DIV_DVD_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic             fits;

   // Quotient must fit QUO_W bits, so the top of the dividend starts below the divisor
   assign trial    = {rem_ff, low_ff[QUO_W-1]};
   assign fits     = trial >= {1'b0, dvs_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend[DVD_W-1:QUO_W];
         low_in = dividend[QUO_W-1:0];
         dvs_in = divisor;
         quo_in = '0;
         cnt_in = CNT_W'(QUO_W);
      end else if (cnt_ff != '0) begin
         if (fits) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DVS_W-1:0];
         end
         low_in  = {low_ff[QUO_W-2:0], 1'b0};
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

endmodule

[rtl/adem_core.sv]
// Sequencer and datapath: g conversion, dead band, EMA, pixel mapping, move latch.
module adem_core (
   input  logic                    clock,
   input  logic                    reset,
   input  adem_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  adem_pkg::req_item_type  req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output adem_pkg::rsp_item_type  rsp_item
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_GMUL   = 13'b0000000000010,
      S_GSTART = 13'b0000000000100,
      S_GWAIT  = 13'b0000000001000,
      S_JERK   = 13'b0000000010000,
      S_EMA1   = 13'b0000000100000,
      S_EMA2   = 13'b0000001000000,
      S_EMA3   = 13'b0000010000000,
      S_OSEL   = 13'b0000100000000,
      S_OMUL   = 13'b0001000000000,
      S_OSTART = 13'b0010000000000,
      S_OWAIT  = 13'b0100000000000,
      S_PLACE  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;

   logic signed [16:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [15:0] gx_ff, gx_in, gy_ff, gy_in;
   logic signed [15:0] prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic signed [16:0] bandx_ff, bandx_in, bandy_ff, bandy_in;
   logic signed [19:0] smx_ff, smx_in, smy_ff, smy_in;
   logic signed [43:0] prod_ff, prod_in;
   logic signed [34:0] acc_ff, acc_in;
   logic [16:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in, mid_ff, mid_in;
   logic signed [12:0] offx_ff, offx_in, offy_ff, offy_in;
   logic [12:0]        latx_ff, latx_in, laty_ff, laty_in;
   logic               rsp_valid_ff, rsp_valid_in;
   adem_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // Shared multiplier operands
   logic signed [20:0] mul_a;
   logic signed [22:0] mul_b;
   logic               mul_en;

   // Divider hookup
   logic                              div_start, div_done;
   logic [adem_pkg::DIV_DVD_W-1:0]    div_dividend;
   logic [adem_pkg::DIV_DVS_W-1:0]    div_divisor;
   logic [adem_pkg::DIV_QUO_W-1:0]    div_quot;

   // Derived configuration
   logic [12:0]        alpha_eff;
   logic [15:0]        knee16;
   logic [11:0]        inner16, outer16;
   logic signed [12:0] diff16;
   logic [12:0]        diff_abs;

   // Axis-selected values
   logic signed [16:0] ax_sel;
   logic signed [19:0] sm_sel;
   logic signed [16:0] band_sel;
   logic [16:0]        ax_mag;
   logic [19:0]        sm_mag;

   // Per-step results
   logic signed [15:0] g_conv;
   logic [17:0]        jerk;
   logic [11:0]        dead;
   logic signed [34:0] ema_sum;
   logic [11:0]        q12;
   logic signed [13:0] pix;
   logic signed [12:0] off_new;
   logic [12:0]        posx, posy;
   logic               moved;
   logic               out_free;

   function automatic logic [16:0] abs_diff16(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
      logic signed [16:0] d;
      d = 17'(a) - 17'(b);
      return d[16] ? 17'(-d) : 17'(d);
   endfunction

   function automatic logic signed [16:0] apply_band(input logic signed [15:0] g,
                                                     input logic [11:0] band);
      logic signed [16:0] gw, dw, res;
      gw = 17'(g);
      dw = $signed({5'b0, band});
      if (gw > dw) begin
         res = gw - dw;
      end else if (gw < -dw) begin
         res = gw + dw;
      end else begin
         res = '0;
      end
      return res;
   endfunction

   function automatic logic [12:0] place(input logic signed [12:0] off,
                                         input logic [8:0] center,
                                         input logic [7:0] outer);
      logic signed [15:0] p, lo, hi;
      p  = $signed({3'b0, center, 4'b0}) + 16'(off) - 16'sd160;
      lo = $signed({3'b0, center, 4'b0}) - $signed({4'b0, outer, 4'b0});
      hi = $signed({3'b0, center, 4'b0}) + $signed({4'b0, outer, 4'b0}) - 16'sd320;
      if (p < lo) p = lo;
      if (p > hi) p = hi;
      if (p < 16'sd0) p = 16'sd0;
      if (p > 16'sd8191) p = 16'sd8191;
      return p[12:0];
   endfunction

   function automatic logic [12:0] abs_diff13(input logic [12:0] a, input logic [12:0] b);
      return (a > b) ? 13'(a - b) : 13'(b - a);
   endfunction

   function automatic logic signed [15:0] filtered(input logic signed [19:0] s);
      logic signed [20:0] t;
      logic signed [16:0] u;
      t = 21'(s) + 21'sd8;
      u = t[20:4];
      if (u > 17'sd32767) return 16'sh7FFF;
      if (u < -17'sd32768) return 16'sh8000;
      return u[15:0];
   endfunction

   adem_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign alpha_eff = (cfg.smoothing_alpha > adem_pkg::ALPHA_ONE) ? adem_pkg::ALPHA_ONE
                                                                  : cfg.smoothing_alpha;
   assign knee16    = {((cfg.knee_level == '0) ? 12'd1 : cfg.knee_level), 4'b0};
   assign inner16   = {cfg.inner_radius, 4'b0};
   assign outer16   = {cfg.outer_radius, 4'b0};
   assign diff16    = $signed({1'b0, outer16}) - $signed({1'b0, inner16});
   assign diff_abs  = diff16[12] ? 13'(-diff16) : 13'(diff16);

   assign ax_sel   = axis_ff ? ay_ff : ax_ff;
   assign sm_sel   = axis_ff ? smy_ff : smx_ff;
   assign band_sel = axis_ff ? bandy_ff : bandx_ff;
   assign ax_mag   = ax_sel[16] ? 17'(-ax_sel) : 17'(ax_sel);
   assign sm_mag   = sm_sel[19] ? 20'(-sm_sel) : 20'(sm_sel);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (state_ff)
         S_GMUL: begin
            mul_a  = $signed({4'b0, ax_mag});
            mul_b  = adem_pkg::G_SCALE;
            mul_en = 1'b1;
         end
         S_EMA1: begin
            mul_a  = 21'(sm_sel);
            mul_b  = $signed({10'b0, 13'(adem_pkg::ALPHA_ONE - alpha_eff)});
            mul_en = 1'b1;
         end
         S_EMA2: begin
            mul_a  = 21'(band_sel);
            mul_b  = $signed({10'b0, alpha_eff});
            mul_en = 1'b1;
         end
         S_OMUL: begin
            mul_a  = mid_ff ? $signed({4'b0, 17'(mag_ff - {1'b0, knee16})})
                            : $signed({4'b0, mag_ff});
            mul_b  = mid_ff ? $signed({11'b0, diff_abs[11:0]}) : $signed({11'b0, inner16});
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = mul_en ? (mul_a * mul_b) : prod_ff;

   // Divider operand select
   assign div_start    = (state_ff == S_GSTART) || (state_ff == S_OSTART);
   assign div_dividend = (state_ff == S_GSTART) ? (prod_ff[36:0] + adem_pkg::G_ROUND)
                                                : prod_ff[36:0];
   assign div_divisor  = (state_ff == S_GSTART) ? adem_pkg::G_DIVISOR :
                         mid_ff ? 21'(17'd65536 - {1'b0, knee16}) : 21'(knee16);

   // Saturate the converted magnitude and apply the sign
   always_comb begin
      if (!ax_sel[16]) begin
         g_conv = (div_quot > 16'd32767) ? 16'sh7FFF : $signed(div_quot);
      end else begin
         g_conv = (div_quot > 16'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, div_quot}));
      end
   end

   assign jerk = 18'(abs_diff16(gx_ff, prevx_ff)) + 18'(abs_diff16(gy_ff, prevy_ff));
   assign dead = (jerk >= adem_pkg::JERK_HIGH) ? cfg.dead_band_min :
                 (jerk >= adem_pkg::JERK_MID)  ? {1'b0, cfg.dead_band_base[11:1]} :
                                                 cfg.dead_band_base;

   assign ema_sum = acc_ff + (35'(prod_ff) <<< 4);

   // Offset from the quotient: low segment is the quotient, middle segment moves it from inner toward outer
   assign q12 = div_quot[11:0];
   assign pix = mid_ff ? ($signed({2'b0, inner16}) +
                          (diff16[12] ? -$signed({2'b0, q12}) : $signed({2'b0, q12})))
                       : $signed({2'b0, q12});
   assign off_new = neg_ff ? 13'(-pix) : 13'(pix);

   assign posx  = place(offx_ff, cfg.plot_center, cfg.outer_radius);
   assign posy  = place(offy_ff, cfg.plot_center, cfg.outer_radius);
   assign moved = (abs_diff13(posx, latx_ff) > {5'b0, cfg.move_threshold}) ||
                  (abs_diff13(posy, laty_ff) > {5'b0, cfg.move_threshold});

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      prevx_in     = prevx_ff;
      prevy_in     = prevy_ff;
      bandx_in     = bandx_ff;
      bandy_in     = bandy_ff;
      smx_in       = smx_ff;
      smy_in       = smy_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mid_in       = mid_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;
      latx_in      = latx_ff;
      laty_in      = laty_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_item.mode) begin
                  // Clear the filter, keep the latched position
                  smx_in   = '0;
                  smy_in   = '0;
                  prevx_in = '0;
                  prevy_in = '0;
               end else begin
                  ax_in    = 17'(-17'(req_item.accel_lateral));
                  ay_in    = 17'(req_item.accel_vertical);
                  axis_in  = 1'b0;
                  state_in = S_GMUL;
               end
            end
         end
         S_GMUL:   state_in = S_GSTART;
         S_GSTART: state_in = S_GWAIT;
         S_GWAIT: begin
            if (div_done) begin
               if (!axis_ff) begin
                  gx_in    = g_conv;
                  axis_in  = 1'b1;
                  state_in = S_GMUL;
               end else begin
                  gy_in    = g_conv;
                  axis_in  = 1'b0;
                  state_in = S_JERK;
               end
            end
         end
         S_JERK: begin
            bandx_in = apply_band(gx_ff, dead);
            bandy_in = apply_band(gy_ff, dead);
            prevx_in = gx_ff;
            prevy_in = gy_ff;
            state_in = S_EMA1;
         end
         S_EMA1: state_in = S_EMA2;
         S_EMA2: begin
            acc_in   = 35'(prod_ff) + 35'sd2048;
            state_in = S_EMA3;
         end
         S_EMA3: begin
            if (!axis_ff) begin
               smx_in = ema_sum[31:12];
            end else begin
               smy_in = ema_sum[31:12];
            end
            state_in = S_OSEL;
         end
         S_OSEL: begin
            neg_in = sm_sel[19];
            mag_in = sm_mag[16:0];
            if (sm_mag <= {4'b0, knee16}) begin
               mid_in   = 1'b0;
               state_in = S_OMUL;
            end else if (sm_mag <= 20'd65536) begin
               mid_in   = 1'b1;
               state_in = S_OMUL;
            end else begin
               // Past 1 g: saturate at the outer radius
               if (!axis_ff) begin
                  offx_in = sm_sel[19] ? -$signed({1'b0, outer16}) : $signed({1'b0, outer16});
                  axis_in  = 1'b1;
                  state_in = S_EMA1;
               end else begin
                  offy_in = sm_sel[19] ? -$signed({1'b0, outer16}) : $signed({1'b0, outer16});
                  axis_in  = 1'b0;
                  state_in = S_PLACE;
               end
            end
         end
         S_OMUL:   state_in = S_OSTART;
         S_OSTART: state_in = S_OWAIT;
         S_OWAIT: begin
            if (div_done) begin
               if (!axis_ff) begin
                  offx_in  = off_new;
                  axis_in  = 1'b1;
                  state_in = S_EMA1;
               end else begin
                  offy_in  = off_new;
                  axis_in  = 1'b0;
                  state_in = S_PLACE;
               end
            end
         end
         S_PLACE: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_item_in.marker_x   = posx[12:4];
               rsp_item_in.marker_y   = posy[12:4];
               rsp_item_in.moved      = moved;
               rsp_item_in.filtered_x = filtered(smx_ff);
               rsp_item_in.filtered_y = filtered(smy_ff);
               rsp_valid_in           = 1'b1;
               if (moved) begin
                  latx_in = posx;
                  laty_in = posy;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         smx_ff       <= '0;
         smy_ff       <= '0;
         prevx_ff     <= '0;
         prevy_ff     <= '0;
         latx_ff      <= '0;
         laty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         smx_ff       <= smx_in;
         smy_ff       <= smy_in;
         prevx_ff     <= prevx_in;
         prevy_ff     <= prevy_in;
         latx_ff      <= latx_in;
         laty_ff      <= laty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      bandx_ff    <= bandx_in;
      bandy_ff    <= bandy_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      mid_ff      <= mid_in;
      offx_ff     <= offx_in;
      offy_ff     <= offy_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

[rtl/accel_deadband_ema_plotter_top.sv]
// Top level of the adaptive dead-band EMA g-force plotter.
// An axis whose smoothed value lies beyond 1 g skips its offset division and saturates at the
// outer radius. A clear item leaves the sequencer idle and produces no result.
// Samples are taken one at a time; a new one is accepted only when the sequencer is back in idle.
// The shared 16-step divider runs up to four times per sample (two g conversions, two offsets).
// Reset: synchronous; registers return to defaults, filter and latch state to zero.
module accel_deadband_ema_plotter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  adem_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output adem_pkg::rsp_item_type            rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [adem_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [adem_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [adem_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   adem_pkg::cfg_type cfg;

   adem_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   adem_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // A sample transfer occupies the sequencer
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_item.mode) |=> req_stall)
      else $error("sequencer took no work after a sample transfer");

   // A clear item never produces a result
   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_item.mode && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared after a clear item");

   // A result is only produced at the end of a busy sequence
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while the sequencer was idle");

endmodule

[dv/accel_deadband_ema_plotter_checker.sv]
// Predicts every marker result from observed transfers and compares it with the block's output.
`timescale 1ns / 100ps

module accel_deadband_ema_plotter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  adem_pkg::req_item_type            req_item,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  adem_pkg::rsp_item_type            rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [adem_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [adem_pkg::CSR_DATA_W-1:0]   pwdata,
   output int                                mismatch_count,
   output int                                markers_due
);
   import adem_pkg::*;

   cfg_type      cfg = CFG_RESET;
   int           smooth_x, smooth_y;     // g Q3.16
   int           prev_gx, prev_gy;       // g Q3.12
   int           latch_x, latch_y;       // pixels Q9.4
   int           fails = 0;
   rsp_item_type pending_markers[$];

   function automatic int clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   // m/s^2 Q8.8 to g Q3.12, rounded half away from zero
   function automatic int accel_to_g(longint a);
      longint mag, q;
      mag = (a < 0) ? -a : a;
      q = (2 * mag * 1600000 + 980665) / 1961330;
      if (a < 0) q = -q;
      return clamp16(q);
   endfunction

   function automatic int apply_dead_band(int g, longint jerk);
      int band;
      if (jerk * 20 > 4096) band = int'(cfg.dead_band_min);
      else if (jerk * 50 > 4096) band = int'(cfg.dead_band_base >> 1);
      else band = int'(cfg.dead_band_base);
      if (g > band) return g - band;
      if (g < -band) return g + band;
      return 0;
   endfunction

   function automatic int blend_average(int s, int g);
      longint a, v;
      a = (cfg.smoothing_alpha > ALPHA_ONE) ? 64'sd4096 : longint'(cfg.smoothing_alpha);
      v = longint'(s) * (4096 - a) + longint'(g) * 16 * a + 2048;
      return int'(v >>> 12);
   endfunction

   function automatic longint pixel_offset(int s);
      longint mag, knee, inner, outer, px;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      if (cfg.knee_level == 0) knee = 16;
      else knee = longint'(cfg.knee_level) * 16;
      inner = longint'(cfg.inner_radius) * 16;
      outer = longint'(cfg.outer_radius) * 16;
      if (mag <= knee) px = mag * inner / knee;
      else if (mag <= 65536) px = inner + (mag - knee) * (outer - inner) / (65536 - knee);
      else px = outer;
      return (s < 0) ? -px : px;
   endfunction

   function automatic int place_marker(longint off);
      longint c, o, p;
      c = longint'(cfg.plot_center);
      o = longint'(cfg.outer_radius);
      p = c * 16 + off - 160;
      if (p < (c - o) * 16) p = (c - o) * 16;
      // upper bound wins when the two bounds cross
      if (p > (c + o - 20) * 16) p = (c + o - 20) * 16;
      if (p < 0) p = 0;
      if (p > 8191) p = 8191;
      return int'(p);
   endfunction

   function automatic int distance(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   task automatic predict_marker(input req_item_type it);
      int           gx, gy, px, py;
      longint       jerk;
      rsp_item_type m;
      gx = accel_to_g(-longint'(it.accel_lateral));
      gy = accel_to_g(longint'(it.accel_vertical));
      jerk = longint'(distance(gx, prev_gx)) + longint'(distance(gy, prev_gy));
      prev_gx = gx;
      prev_gy = gy;
      smooth_x = blend_average(smooth_x, apply_dead_band(gx, jerk));
      smooth_y = blend_average(smooth_y, apply_dead_band(gy, jerk));
      px = place_marker(pixel_offset(smooth_x));
      py = place_marker(pixel_offset(smooth_y));
      m.moved = 1'b0;
      if (distance(px, latch_x) > int'(cfg.move_threshold) ||
          distance(py, latch_y) > int'(cfg.move_threshold)) begin
         latch_x = px;
         latch_y = py;
         m.moved = 1'b1;
      end
      m.marker_x   = 9'(px >> 4);
      m.marker_y   = 9'(py >> 4);
      m.filtered_x = 16'(clamp16((longint'(smooth_x) + 8) >>> 4));
      m.filtered_y = 16'(clamp16((longint'(smooth_y) + 8) >>> 4));
      pending_markers.push_back(m);
   endtask

   task automatic compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type m;
      if (reset) begin
         cfg = CFG_RESET;
         smooth_x = 0;
         smooth_y = 0;
         prev_gx = 0;
         prev_gy = 0;
         latch_x = 0;
         latch_y = 0;
         pending_markers.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_DB_BASE:   cfg.dead_band_base  = pwdata[11:0];
               REG_DB_MIN:    cfg.dead_band_min   = pwdata[11:0];
               REG_ALPHA:     cfg.smoothing_alpha = pwdata[12:0];
               REG_KNEE:      cfg.knee_level      = pwdata[11:0];
               REG_INNER:     cfg.inner_radius    = pwdata[7:0];
               REG_OUTER:     cfg.outer_radius    = pwdata[7:0];
               REG_CENTER:    cfg.plot_center     = pwdata[8:0];
               REG_THRESHOLD: cfg.move_threshold  = pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_markers.size() == 0) begin
               $display("%0t: result with nothing expected, got x=%0d y=%0d moved=%0b",
                        $time, rsp_item.marker_x, rsp_item.marker_y, rsp_item.moved);
               fails++;
            end else begin
               m = pending_markers.pop_front();
               compare_field("marker_x", m.marker_x, rsp_item.marker_x);
               compare_field("marker_y", m.marker_y, rsp_item.marker_y);
               compare_field("moved", m.moved, rsp_item.moved);
               compare_field("filtered_x", m.filtered_x, rsp_item.filtered_x);
               compare_field("filtered_y", m.filtered_y, rsp_item.filtered_y);
            end
         end
         if (req_valid && !req_stall) begin
            // clear drops the filter history but keeps the latched position
            if (req_item.mode) begin
               smooth_x = 0;
               smooth_y = 0;
               prev_gx = 0;
               prev_gy = 0;
            end else begin
               predict_marker(req_item);
            end
         end
      end
      mismatch_count <= fails;
      markers_due <= pending_markers.size();
   end

endmodule

[dv/accel_deadband_ema_plotter_top_tb.sv]
// Testbench top: clock, reset, stimulus and register setup for the g-force plotter.
`timescale 1ns / 100ps

module accel_deadband_ema_plotter_top_tb;
   import adem_pkg::*;

   localparam int IDLE_LIMIT      = 4000;
   localparam int LONG_HOLD       = 600;
   localparam int SETTLE_CYCLES   = 100;
   localparam int ITEMS_PER_PHASE = 62;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count;
   int markers_due;
   int items_sent = 0;
   int burst_left = 1;
   int idle_cycles = 0;
   int lat_walk = 0;
   int vert_walk = 0;

   accel_deadband_ema_plotter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   accel_deadband_ema_plotter_checker marker_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .markers_due    (markers_due)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: stall patterns of random density, plus one long hold-off mid-run
   initial begin
      int  span;
      int  pct;
      bit  held;
      held = 1'b0;
      forever begin
         if (!held && items_sent >= 300) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         span = $urandom_range(20, 400);
         case ($urandom_range(0, 2))
            0: pct = 0;
            1: pct = 30;
            default: pct = 75;
         endcase
         repeat (span) begin
            rsp_stall <= ($urandom_range(0, 99) < pct);
            @(posedge clock);
         end
      end
   end

   // Offer one item and hold it until transfer; end the burst with a random gap
   task automatic push(input logic mode, input logic signed [15:0] lat,
                       input logic signed [15:0] vert);
      req_item_type it;
      it.mode = mode;
      it.accel_lateral = lat;
      it.accel_vertical = vert;
      req_item <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 130)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type s);
      write_reg(REG_DB_BASE, 32'(s.dead_band_base));
      write_reg(REG_DB_MIN, 32'(s.dead_band_min));
      write_reg(REG_ALPHA, 32'(s.smoothing_alpha));
      write_reg(REG_KNEE, 32'(s.knee_level));
      write_reg(REG_INNER, 32'(s.inner_radius));
      write_reg(REG_OUTER, 32'(s.outer_radius));
      write_reg(REG_CENTER, 32'(s.plot_center));
      write_reg(REG_THRESHOLD, 32'(s.move_threshold));
   endtask

   // Hold off until every result is back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (markers_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic cfg_type random_settings();
      cfg_type s;
      s.dead_band_base = 12'($urandom);
      s.dead_band_min  = 12'($urandom);
      if ($urandom_range(0, 3) == 0) s.smoothing_alpha = 13'($urandom);
      else s.smoothing_alpha = 13'($urandom_range(1, 4096));
      s.knee_level   = 12'($urandom);
      s.inner_radius = 8'($urandom);
      s.outer_radius = 8'($urandom);
      s.plot_center  = 9'($urandom);
      if ($urandom_range(0, 3) == 0) s.move_threshold = 8'($urandom);
      else s.move_threshold = 8'($urandom_range(0, 64));
      return s;
   endfunction

   // Random walk: mostly small steps (low jerk), some medium, a few large
   function automatic int drift(input int v);
      int r;
      int delta;
      r = $urandom_range(0, 9);
      if (r < 6) delta = int'($urandom_range(0, 24)) - 12;
      else if (r < 8) delta = int'($urandom_range(0, 120)) - 60;
      else delta = int'($urandom_range(0, 3000)) - 1500;
      v = v + delta;
      if (v > 12000 || v < -12000) v = v / 2;
      return v;
   endfunction

   task automatic random_items(input int count);
      int kind;
      logic [15:0] rails [4];
      rails[0] = 16'h7fff;
      rails[1] = 16'h8000;
      rails[2] = 16'h0000;
      rails[3] = 16'hffff;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         if (kind < 5) begin
            push(1'b1, 16'($urandom), 16'($urandom));
         end else if (kind < 15) begin
            push(1'b0, 16'($urandom), 16'($urandom));
         end else if (kind < 20) begin
            push(1'b0, rails[$urandom_range(0, 3)], rails[$urandom_range(0, 3)]);
         end else begin
            lat_walk = drift(lat_walk);
            vert_walk = drift(vert_walk);
            push(1'b0, 16'(lat_walk), 16'(vert_walk));
         end
      end
   endtask

   initial begin
      cfg_type corners [5];
      // field order: base, min, alpha, knee, inner, outer, center, threshold
      corners[0] = '{12'd0, 12'd0, 13'd1, 12'd1, 8'd0, 8'd0, 9'd0, 8'd0};
      corners[1] = '{12'd4095, 12'd4095, 13'd4096, 12'd4095, 8'd255, 8'd255, 9'd511, 8'd255};
      // alpha zero, knee zero, descending middle segment
      corners[2] = '{12'd1000, 12'd10, 13'd0, 12'd0, 8'd200, 8'd30, 9'd5, 8'd8};
      // alpha above one, crossed clamp bounds
      corners[3] = '{12'd4095, 12'd0, 13'd8191, 12'd2000, 8'd40, 8'd5, 9'd300, 8'd1};
      corners[4] = '{12'd0, 12'd0, 13'd4096, 12'd4095, 8'd255, 8'd255, 9'd0, 8'd0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(1, 12);

      // directed items at reset settings
      push(1'b0, 16'sd0, 16'sd0);
      push(1'b0, 16'h7fff, 16'h8000);
      push(1'b0, 16'h8000, 16'h7fff);
      push(1'b0, 16'h8000, 16'h7fff);
      push(1'b1, 16'h7fff, 16'h8000);
      push(1'b0, -16'sd2511, 16'sd2511);
      push(1'b0, -16'sd2511, 16'sd2511);
      push(1'b0, 16'sd753, -16'sd753);
      push(1'b0, 16'sd760, -16'sd745);
      push(1'b0, 16'sd800, -16'sd700);
      push(1'b0, 16'sd201, 16'sd202);
      push(1'b0, 16'sd201, 16'sd202);
      push(1'b0, 16'sd205, 16'sd198);
      push(1'b0, -16'sd1, 16'sd1);
      push(1'b0, 16'sd1, -16'sd1);
      push(1'b1, 16'sd0, 16'sd0);
      push(1'b0, 16'sd5000, -16'sd5000);
      push(1'b0, 16'sd12000, 16'sd12000);
      push(1'b0, -16'sd21000, -16'sd21000);
      push(1'b0, 16'sd0, 16'sd0);
      random_items(ITEMS_PER_PHASE);
      drain_results();

      for (int i = 0; i < 5; i++) begin
         load_settings(corners[i]);
         random_items(ITEMS_PER_PHASE);
         drain_results();
      end
      for (int i = 0; i < 5; i++) begin
         load_settings(random_settings());
         random_items(ITEMS_PER_PHASE);
         drain_results();
      end
      load_settings(CFG_RESET);
      random_items(ITEMS_PER_PHASE);
      drain_results();

      if (mismatch_count == 0 && markers_due == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
